[rtl/core/histogram_equalizer_defines.svh]
// ----------------------------------------------------------------------------
// histogram_equalizer_defines.svh
// Assertion macros shared by the histogram equalizer RTL.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH

`ifndef SYNTH
`define HEQ_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`define HEQ_ASSERT_LAT2(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##2 (b)) \
    else $error("assertion failed");
`else
`define HEQ_ASSERT_NEXT(label, a, b)
`define HEQ_ASSERT_LAT2(label, a, b)
`endif

`endif

[rtl/core/heq_pkg.sv]
// ----------------------------------------------------------------------------
// heq_pkg
// Types and constants shared by the histogram equalizer modules.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  // register select: paddr bit 2 picks the 32-bit word
  localparam logic        REG_MAX_LEVEL = 1'b0;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'hFF;

  typedef struct packed {
    logic capture;     // latch pixel and last mark
    logic item_rd;     // read bin of the latched pixel
    logic item_inc;    // write back bin + 1, bump total
    logic sweep_rd;    // read bin at sweep index
    logic sweep_clr;   // zero bin at sweep index
    logic acc;         // cumulative += bin
    logic mul;         // remainder = cum * max_level
    logic div_step;    // one quotient bit
    logic map_wr;      // store quotient in level map
    logic map_rd;      // read level map for latched pixel
    logic sweep_next;  // advance sweep index
    logic finish;      // clear total, cum, sweep index
  } cmd_t;

  typedef struct packed {
    logic last;
    logic sweep_end;
    logic div_end;
  } stat_t;

endpackage

[rtl/core/heq_ctrl.sv]
// ----------------------------------------------------------------------------
// heq_ctrl
// Sequencer for count, map, table build and post-reset bin clear.
// ----------------------------------------------------------------------------
module heq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           operation_i,
  input  heq_pkg::stat_t stat_i,
  output heq_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           strobe_o
);
  import heq_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_C_RD, S_C_WR, S_M_RD, S_M_OUT,
    S_B_RD, S_B_ACC, S_B_MUL, S_B_DIV, S_B_WR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLR: begin
        cmd_o.sweep_clr = 1'b1;
        if (stat_i.sweep_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.sweep_next = 1'b1;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = operation_i ? S_M_RD : S_C_RD;
        end
      end
      S_C_RD: begin
        cmd_o.item_rd = 1'b1;
        state_d       = S_C_WR;
      end
      S_C_WR: begin
        cmd_o.item_inc = 1'b1;
        state_d        = stat_i.last ? S_B_RD : S_IDLE;
      end
      S_M_RD: begin
        cmd_o.map_rd = 1'b1;
        state_d      = S_M_OUT;
      end
      S_M_OUT: state_d = S_IDLE;
      S_B_RD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d        = S_B_ACC;
      end
      S_B_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.sweep_clr = 1'b1;
        state_d         = S_B_MUL;
      end
      S_B_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_B_DIV;
      end
      S_B_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_end) state_d = S_B_WR;
      end
      S_B_WR: begin
        cmd_o.map_wr = 1'b1;
        if (stat_i.sweep_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.sweep_next = 1'b1;
          state_d          = S_B_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign strobe_o = (state_q == S_M_OUT);

endmodule

[rtl/core/heq_datapath.sv]
// ----------------------------------------------------------------------------
// heq_datapath
// Bin and map memories, pixel total, cumulative sum and bit-serial divider.
// ----------------------------------------------------------------------------
module heq_datapath #(
  parameter int unsigned LEVELS     = 256,
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  heq_pkg::cmd_t                cmd_i,
  input  logic [heq_pkg::LEVEL_W-1:0]  pixel_i,
  input  logic                         last_pixel_i,
  input  logic [heq_pkg::LEVEL_W-1:0]  max_level_i,
  output heq_pkg::stat_t               stat_o,
  output logic [heq_pkg::LEVEL_W-1:0]  mapped_pixel_o
);
  import heq_pkg::*;

  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PROD_W = CNT_W + LEVEL_W;

  logic [CNT_W-1:0]   bin_mem [LEVELS];
  logic [LEVEL_W-1:0] map_mem [LEVELS];

  logic [LVL_W-1:0]   idx_q, v_q, in_idx;
  logic               last_q, built_q;
  logic [CNT_W-1:0]   bin_rd_q, total_q, cum_q;
  logic [LEVEL_W-1:0] map_rd_q, quo_q;
  logic [PROD_W-1:0]  rem_q, div_sh;
  logic [2:0]         k_q;
  logic               full;
  logic               bin_we;
  logic [LVL_W-1:0]   bin_wa;
  logic [CNT_W-1:0]   bin_wd;

  // pixels beyond the last bin fold into it
  always_comb begin
    if ({1'b0, pixel_i} >= (LEVEL_W+1)'(LEVELS)) in_idx = LVL_W'(LEVELS - 1);
    else in_idx = pixel_i[LVL_W-1:0];
  end

  assign full   = (total_q >= CNT_W'(MAX_PIXELS));
  assign bin_we = (cmd_i.item_inc && !full) || cmd_i.sweep_clr;
  assign bin_wa = cmd_i.sweep_clr ? v_q : idx_q;
  assign bin_wd = cmd_i.sweep_clr ? '0 : bin_rd_q + CNT_W'(1);
  assign div_sh = PROD_W'(total_q) << k_q;

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (cmd_i.item_rd || cmd_i.sweep_rd) begin
      bin_rd_q <= bin_mem[cmd_i.sweep_rd ? v_q : idx_q];
    end
    if (cmd_i.map_wr) map_mem[v_q] <= (total_q == '0) ? '0 : quo_q;
    if (cmd_i.map_rd) map_rd_q <= map_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q  <= in_idx;
      last_q <= last_pixel_i;
    end
    if (cmd_i.mul) begin
      rem_q <= PROD_W'(cum_q) * PROD_W'(max_level_i);
      quo_q <= '0;
      k_q   <= '1;
    end else if (cmd_i.div_step) begin
      if (rem_q >= div_sh) begin
        rem_q        <= rem_q - div_sh;
        quo_q[k_q]   <= 1'b1;
      end
      k_q <= k_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      cum_q   <= '0;
      v_q     <= '0;
      built_q <= 1'b0;
    end else begin
      if (cmd_i.item_inc && !full) total_q <= total_q + CNT_W'(1);
      if (cmd_i.acc) cum_q <= cum_q + bin_rd_q;
      if (cmd_i.map_wr) built_q <= 1'b1;
      if (cmd_i.sweep_next) v_q <= v_q + LVL_W'(1);
      if (cmd_i.finish) begin
        total_q <= '0;
        cum_q   <= '0;
        v_q     <= '0;
      end
    end
  end

  assign stat_o.last      = last_q;
  assign stat_o.sweep_end = (v_q == LVL_W'(LEVELS - 1));
  assign stat_o.div_end   = (k_q == 3'd0);
  assign mapped_pixel_o   = built_q ? map_rd_q : '0;

endmodule

[rtl/core/histogram_equalizer.sv]
// ----------------------------------------------------------------------------
// histogram_equalizer
// Two-pass 8-bit histogram equalization with an APB register for max_level.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// item      in         start & !busy (operation, pixel, last_pixel)
// result    out        result_strobe, one cycle (mapped_pixel)
// config    in         APB write: psel & penable & pwrite & pready
//
// Count item: read-modify-write of the bin memory port (S_C_RD, then S_C_WR).
// Map item: level map read in S_M_RD, result strobed from S_M_OUT.
// Last count item adds a table build that takes every bin through read,
// accumulate, multiply, the bit-serial divider and the map write.
// After reset the bin memory is cleared bin by bin; busy is high meanwhile.
// ----------------------------------------------------------------------------
`include "histogram_equalizer_defines.svh"

module histogram_equalizer #(
  parameter int unsigned LEVELS     = 256,
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [heq_pkg::LEVEL_W-1:0]  pixel_i,
  input  logic                         last_pixel_i,
  output logic                         result_strobe_o,
  output logic [heq_pkg::LEVEL_W-1:0]  mapped_pixel_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [heq_pkg::APB_AW-1:0]   paddr,
  input  logic [heq_pkg::APB_DW-1:0]   pwdata,
  output logic [heq_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import heq_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [LEVEL_W-1:0] max_level_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LEVEL) begin
      max_level_q <= pwdata[LEVEL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_LEVEL) ? APB_DW'(max_level_q) : '0;

  heq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .strobe_o    (result_strobe_o)
  );

  heq_datapath #(
    .LEVELS     (LEVELS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .pixel_i        (pixel_i),
    .last_pixel_i   (last_pixel_i),
    .max_level_i    (max_level_q),
    .stat_o         (stat),
    .mapped_pixel_o (mapped_pixel_o)
  );

  `HEQ_ASSERT_LAT2(a_map_result, start && !busy && operation_i, result_strobe_o)
  `HEQ_ASSERT_NEXT(a_count_busy, start && !busy && !operation_i, busy)
  `HEQ_ASSERT_NEXT(a_single_strobe, result_strobe_o, !result_strobe_o)

endmodule

[tb/sv/tb_histogram_equalizer.sv]
// ----------------------------------------------------------------------------
// tb_histogram_equalizer
// Self-checking bench for the histogram equalizer: count and map items with
// random gaps, max_level changed over APB between frames, map results checked
// against an in-bench equalization model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_histogram_equalizer;
  import heq_pkg::*;

  localparam int unsigned NUM_LEVELS  = 256;
  localparam int unsigned PIXEL_LIMIT = 1048576;
  localparam logic        OP_COUNT    = 1'b0;
  localparam logic        OP_MAP      = 1'b1;
  localparam logic [APB_AW-1:0] ADDR_MAX_LEVEL = {REG_MAX_LEVEL, 2'b00};
  localparam int unsigned CYCLE_LIMIT = 20000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                operation_i = OP_COUNT;
  logic [LEVEL_W-1:0]  pixel_i = '0;
  logic                last_pixel_i = 1'b0;
  logic                result_strobe_o;
  logic [LEVEL_W-1:0]  mapped_pixel_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  histogram_equalizer u_top (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .pixel_i, .last_pixel_i,
    .result_strobe_o, .mapped_pixel_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // equalization model
  int unsigned         bin_tally [NUM_LEVELS];
  int unsigned         frame_total;
  logic [LEVEL_W-1:0]  eq_map [NUM_LEVELS];
  logic [LEVEL_W-1:0]  cur_max_level;
  logic [LEVEL_W-1:0]  pending_levels [$];
  int unsigned         mismatches;
  int unsigned         cycles;

  task automatic build_eq_map();
    longint unsigned cum;
    longint unsigned q;
    cum = 0;
    for (int v = 0; v < NUM_LEVELS; v++) begin
      cum += bin_tally[v];
      q = (frame_total != 0) ? (cum * cur_max_level) / frame_total : 0;
      if (q > 255) q = 255;
      eq_map[v] = q[LEVEL_W-1:0];
      bin_tally[v] = 0;
    end
    frame_total = 0;
  endtask

  task automatic predict_item(logic op, logic [LEVEL_W-1:0] pix, logic lst);
    if (op == OP_MAP) begin
      pending_levels.push_back(eq_map[pix]);
    end else begin
      if (frame_total < PIXEL_LIMIT) begin
        bin_tally[pix]++;
        frame_total++;
      end
      if (lst) build_eq_map();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_strobe_o) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", mapped_pixel_o);
      end else begin
        logic [LEVEL_W-1:0] want;
        want = pending_levels.pop_front();
        if (mapped_pixel_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mapped_pixel mismatch: expected %0d got %0d", want, mapped_pixel_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // start stays high across a zero-length gap; the next item takes over
  task automatic random_gap();
    int unsigned n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 30);
    if (n != 0) start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // send one item; returns at a falling edge after acceptance
  task automatic send_item(logic op, logic [LEVEL_W-1:0] pix, logic lst, bit gaps = 1);
    start <= 1'b1;
    operation_i <= op;
    pixel_i <= pix;
    last_pixel_i <= lst;
    do @(posedge clk_i); while (busy);
    predict_item(op, pix, lst);
    @(negedge clk_i);
    if (gaps) random_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_max_level(logic [LEVEL_W-1:0] lvl);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_MAX_LEVEL; pwdata <= {{(APB_DW-LEVEL_W){1'b0}}, lvl};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_max_level = lvl;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic map_sweep_ends();
    send_item(OP_MAP, 8'd0, 1'b0);
    send_item(OP_MAP, 8'd255, 1'b1);   // last mark on map item is ignored
    send_item(OP_MAP, 8'd128, 1'b0);
  endtask

  task automatic test_directed();
    map_sweep_ends();                  // map before any build gives zero
    send_item(OP_COUNT, 8'd0, 1'b0);
    send_item(OP_COUNT, 8'd255, 1'b0);
    send_item(OP_COUNT, 8'd255, 1'b0);
    send_item(OP_COUNT, 8'd85, 1'b1);
    map_sweep_ends();
    send_item(OP_MAP, 8'd85, 1'b0);
    send_item(OP_COUNT, 8'd17, 1'b1);  // single pixel frame
    map_sweep_ends();
    write_max_level(8'd1);
    send_item(OP_COUNT, 8'd3, 1'b0);
    send_item(OP_COUNT, 8'd200, 1'b1);
    map_sweep_ends();
  endtask

  // single-pixel frame closed by its own last mark
  task automatic test_empty_frame();
    send_item(OP_COUNT, 8'd42, 1'b1);
    send_item(OP_MAP, 8'd42, 1'b0);
    drain();
    // map from idle after the build settled
    send_item(OP_MAP, 8'd0, 1'b0);
  endtask

  task automatic random_frame(int unsigned n_items);
    int unsigned skew;
    skew = $urandom_range(0, 3);
    for (int i = 0; i < n_items; i++) begin
      logic [LEVEL_W-1:0] pix;
      pix = (skew == 0) ? LEVEL_W'($urandom_range(0, 255)) :
            (skew == 1) ? LEVEL_W'($urandom_range(0, 15)) :
            (skew == 2) ? LEVEL_W'($urandom_range(240, 255)) :
                          LEVEL_W'($urandom_range(100, 140));
      if ($urandom_range(0, 3) == 0)
        send_item(OP_MAP, LEVEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        send_item(OP_COUNT, pix, (i == n_items - 1) || ($urandom_range(0, 199) == 0));
    end
    for (int i = 0; i < 12; i++)
      send_item(OP_MAP, LEVEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random();
    int unsigned sent;
    logic [LEVEL_W-1:0] levels [5] = '{8'd255, 8'd1, 8'd128, 8'd7, 8'd200};
    sent = 0;
    for (int f = 0; sent < 1400; f++) begin
      int unsigned n;
      if (f % 6 == 5) write_max_level(levels[(f / 6) % 5]);
      if (f == 8) drain();             // pause until all results are in
      n = $urandom_range(5, 60);
      random_frame(n);
      sent += n + 12;
    end
  endtask

  initial begin
    frame_total = 0;
    cur_max_level = MAX_LEVEL_RST;
    for (int v = 0; v < NUM_LEVELS; v++) begin
      bin_tally[v] = 0;
      eq_map[v] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_max_level(8'd255);
    test_empty_frame();
    test_random();
    drain();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
